// ===== hw/rtl/lst_pkg.sv =====
// shared types and constants for the latency statistics tracker
`default_nettype none

package lst_pkg;

   localparam int DATA_W      = 32;
   localparam int BIN_WIDTH_W = 19;
   localparam int ACC_W       = 48;
   localparam int BIN_OUT_W   = 3;

   localparam int NUM_BINS_DEF         = 7;
   localparam int AVG_SCALE_SHIFT_DEF  = 10;
   localparam int AVG_WEIGHT_SHIFT_DEF = 3;

   localparam logic [DATA_W-1:0] IDLE_TIME_RESET = 32'd1000;
   localparam int                BIN_WIDTH_RESET = 2000;
   localparam logic [DATA_W-1:0] MIN_RESET       = '1;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_IDLE_TIME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BIN_WIDTH = 2'd1;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_FIELD_W = 5 * DATA_W + BIN_OUT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef struct packed {
      logic update;
      logic clear;
   } stats_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/latency_statistics_tracker.sv =====
// top level of the latency statistics tracker
//
// req channel: one transaction per sample; req_tuser is the opcode (add sample
// or clear), req_tdata the elapsed time in microseconds.
// rsp channel: one transaction per request carrying the excess latency, the
// minimum, maximum and weighted average, the bin hit and its new count.
// csr channel: register writes, always ready; index 0 is the idle time,
// index 1 the bin width.
// path: a request waits in the input register and its result in the output
// register, which raises rsp_tvalid; an rsp stall can hold the request between.
// throughput: one request per cycle unless rsp stalls; the state update (min,
// max, average accumulator, bin counter read-increment-write) closes on advance.
// an input register and an output register split the two sides, so a
// request is taken while a result waits; when rsp stalls, the input register
// holds one more request and then req_tready drops.
// reset: synchronous; statistics and bin counters return to their reset
// values, registers to idle time 1000 and bin width 2000.
`default_nettype none

module latency_statistics_tracker
   import lst_pkg::*;
#(
   parameter int NUM_BINS         = NUM_BINS_DEF,
   parameter int AVG_SCALE_SHIFT  = AVG_SCALE_SHIFT_DEF,
   parameter int AVG_WEIGHT_SHIFT = AVG_WEIGHT_SHIFT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // elapsed_us
   input  wire logic                   req_tuser,   // opcode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // latency_us, min_us, max_us, average_us, bin_index, bin_count, zero pad
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]      csr_data
);

   localparam int LIMIT_W = BIN_WIDTH_W + $clog2(NUM_BINS);
   localparam int IDX_W   = $clog2(NUM_BINS);

   logic                    s1_valid_ff;
   logic                    s1_op_ff;
   logic [DATA_W-1:0]       s1_elapsed_ff;
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic                    advance;
   logic                    req_accept;
   logic [DATA_W-1:0]       idle_time;
   logic [LIMIT_W-1:0]      limit [NUM_BINS-1];
   logic [DATA_W-1:0]       latency;
   logic [DATA_W-1:0]       latency_res;
   stats_ctl_type           ctl;
   logic [DATA_W-1:0]       min_val, max_val, avg_val;
   logic [IDX_W-1:0]        bin_idx;
   logic [IDX_W+BIN_OUT_W-1:0] bin_idx_ext;
   logic [DATA_W-1:0]       bin_count;

   assign csr_ready = 1'b1;

   lst_csr #(
      .NUM_BINS (NUM_BINS),
      .LIMIT_W  (LIMIT_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (csr_valid && csr_ready),
      .wr_index  (csr_index),
      .wr_data   (csr_data),
      .idle_time (idle_time),
      .limit     (limit)
   );

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff      <= req_tuser;
         s1_elapsed_ff <= req_tdata;
      end
   end

   assign ctl.clear  = advance && (s1_op_ff == OP_CLEAR);
   assign ctl.update = advance && (s1_op_ff == OP_ADD);

   assign latency     = (s1_elapsed_ff >= idle_time) ? (s1_elapsed_ff - idle_time) : '0;
   assign latency_res = (s1_op_ff == OP_CLEAR) ? '0 : latency;

   lst_running_stats #(
      .AVG_SCALE_SHIFT  (AVG_SCALE_SHIFT),
      .AVG_WEIGHT_SHIFT (AVG_WEIGHT_SHIFT)
   ) u_stats (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .latency (latency),
      .min_out (min_val),
      .max_out (max_val),
      .avg_out (avg_val)
   );

   lst_histogram #(
      .NUM_BINS (NUM_BINS),
      .LIMIT_W  (LIMIT_W),
      .IDX_W    (IDX_W)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .latency   (latency),
      .limit     (limit),
      .bin_idx   (bin_idx),
      .bin_count (bin_count)
   );

   assign bin_idx_ext = {{BIN_OUT_W{1'b0}}, bin_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= RSP_TDATA_W'({bin_count, bin_idx_ext[BIN_OUT_W-1:0],
                                      avg_val, max_val, min_val, latency_res});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // statistics delivered are either the cleared set or an ordered min and max
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[2*DATA_W-1:DATA_W] <= rsp_tdata[3*DATA_W-1:2*DATA_W])
                   || ((rsp_tdata[2*DATA_W-1:DATA_W] == MIN_RESET)
                    && (rsp_tdata[3*DATA_W-1:2*DATA_W] == '0))))
      else $error("min exceeds max in a delivered result");

   // a pending request is kept while the output is stalled
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready)
         |=> (s1_valid_ff && $stable(s1_elapsed_ff) && $stable(s1_op_ff)))
      else $error("pending request lost while output stalled");

   // the selected bin is always a real bin
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      ctl.update |-> (int'(bin_idx) < NUM_BINS))
      else $error("bin index out of range");

   // a stalled result register never takes a new result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/lst_csr.sv =====
// configuration registers with precomputed histogram bin limits
`default_nettype none

module lst_csr
   import lst_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   parameter int LIMIT_W  = BIN_WIDTH_W + $clog2(NUM_BINS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [DATA_W-1:0]      wr_data,
   output logic      [DATA_W-1:0]      idle_time,
   output logic      [LIMIT_W-1:0]     limit [NUM_BINS-1]
);

   logic [DATA_W-1:0]  idle_time_ff;
   logic [LIMIT_W-1:0] limit_ff [NUM_BINS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_time_ff <= IDLE_TIME_RESET;
      end else if (wr_en && (wr_index == REG_IDLE_TIME)) begin
         idle_time_ff <= wr_data;
      end
   end

   // bin k ends at (k+1) * bin width
   for (genvar k = 0; k < NUM_BINS - 1; k++) begin : g_limit
      always_ff @(posedge clock) begin
         if (reset) begin
            limit_ff[k] <= LIMIT_W'((k + 1) * BIN_WIDTH_RESET);
         end else if (wr_en && (wr_index == REG_BIN_WIDTH)) begin
            limit_ff[k] <= LIMIT_W'(k + 1) * LIMIT_W'(wr_data[BIN_WIDTH_W-1:0]);
         end
      end
      assign limit[k] = limit_ff[k];
   end

   assign idle_time = idle_time_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lst_running_stats.sv =====
// running minimum, maximum and weighted average of the latency
`default_nettype none

module lst_running_stats
   import lst_pkg::*;
#(
   parameter int AVG_SCALE_SHIFT  = AVG_SCALE_SHIFT_DEF,
   parameter int AVG_WEIGHT_SHIFT = AVG_WEIGHT_SHIFT_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stats_ctl_type       ctl,
   input  wire logic [DATA_W-1:0]   latency,
   output logic      [DATA_W-1:0]   min_out,
   output logic      [DATA_W-1:0]   max_out,
   output logic      [DATA_W-1:0]   avg_out
);

   localparam int SUM_W = ACC_W + AVG_WEIGHT_SHIFT + 1;

   logic [DATA_W-1:0] min_ff, min_in;
   logic [DATA_W-1:0] max_ff, max_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  scaled;
   logic [SUM_W-1:0]  sum;
   logic [ACC_W-1:0]  acc_shifted;

   assign scaled = ACC_W'(latency) << AVG_SCALE_SHIFT;
   assign sum    = (SUM_W'(acc_ff) << AVG_WEIGHT_SHIFT) - SUM_W'(acc_ff) + SUM_W'(scaled);

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      acc_in = acc_ff;
      if (ctl.clear) begin
         min_in = MIN_RESET;
         max_in = '0;
         acc_in = '0;
      end else if (ctl.update) begin
         min_in = (latency < min_ff) ? latency : min_ff;
         max_in = (latency > max_ff) ? latency : max_ff;
         acc_in = (acc_ff != '0) ? sum[ACC_W+AVG_WEIGHT_SHIFT-1:AVG_WEIGHT_SHIFT] : scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_RESET;
         max_ff <= '0;
         acc_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
         acc_ff <= acc_in;
      end
   end

   assign acc_shifted = acc_in >> AVG_SCALE_SHIFT;
   assign min_out     = min_in;
   assign max_out     = max_in;
   assign avg_out     = acc_shifted[DATA_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/lst_histogram.sv =====
// bin selection by parallel compares and the bin counters
`default_nettype none

module lst_histogram
   import lst_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   parameter int LIMIT_W  = BIN_WIDTH_W + $clog2(NUM_BINS),
   parameter int IDX_W    = $clog2(NUM_BINS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stats_ctl_type       ctl,
   input  wire logic [DATA_W-1:0]   latency,
   input  wire logic [LIMIT_W-1:0]  limit [NUM_BINS-1],
   output logic      [IDX_W-1:0]    bin_idx,
   output logic      [DATA_W-1:0]   bin_count
);

   logic [DATA_W-1:0]   count_ff [NUM_BINS];
   logic [DATA_W-1:0]   count_in;
   logic [NUM_BINS-2:0] past_limit;
   logic [IDX_W-1:0]    sel_idx;

   for (genvar k = 0; k < NUM_BINS - 1; k++) begin : g_cmp
      assign past_limit[k] = latency >= DATA_W'(limit[k]);
   end

   // lowest bin whose upper limit is not reached, else the overflow bin
   always_comb begin
      sel_idx = IDX_W'(NUM_BINS - 1);
      for (int k = NUM_BINS - 2; k >= 0; k--) begin
         if (!past_limit[k]) begin
            sel_idx = IDX_W'(k);
         end
      end
   end

   assign count_in = count_ff[sel_idx] + 1'b1;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (ctl.update) begin
         count_ff[sel_idx] <= count_in;
      end
   end

   assign bin_idx   = ctl.clear ? '0 : sel_idx;
   assign bin_count = ctl.clear ? '0 : count_in;

endmodule

`default_nettype wire
